// ===== hdl/kat_pkg.sv =====
// shared types, codes and helpers for the keyed accumulator table
`timescale 1ns / 1ps

package kat_pkg;

	// default sizing
	localparam int unsigned ENTRIES_DEF   = 256;
	localparam int unsigned KEY_CHARS_DEF = 4;

	// fixed field widths
	localparam int unsigned KEY_W    = 32;
	localparam int unsigned AMOUNT_W = 32;
	localparam int unsigned SLOT_W   = 8;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned KEY_BYTES = KEY_W / 8;

	// request kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_READ  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_ADD   = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_HIT      = 2'd0,
		STAT_INSERTED = 2'd1,
		STAT_FULL     = 2'd2,
		STAT_CLEARED  = 2'd3
	} status_t;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_UPDATE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic issue;
		logic take_hit;
		logic update;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_clear;
		logic hit;
		logic at_end;
		logic exhausted;
		logic out_free;
	} sts_t;

	// key ends at its first zero character, only the first chars count
	function automatic logic [KEY_W-1:0] key_normalize(input logic [KEY_W-1:0] raw,
			input int unsigned chars);
		logic [KEY_W-1:0] res;
		logic             ended;
		res   = '0;
		ended = 1'b0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			if (i < chars && !ended && raw[8*i +: 8] != 8'd0) begin
				res[8*i +: 8] = raw[8*i +: 8];
			end else begin
				ended = 1'b1;
			end
		end
		return res;
	endfunction

endpackage

// ===== hdl/kat_ctrl.sv =====
// controller state machine for the keyed accumulator table
`timescale 1ns / 1ps

module kat_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  kat_pkg::sts_t sts,
	output kat_pkg::cmd_t cmd
);
	import kat_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nxt = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (sts.is_clear || sts.hit || sts.exhausted) begin
					state_nxt = S_UPDATE;
				end
			end
			S_UPDATE: begin
				if (sts.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			S_SEARCH: begin
				cmd.take_hit = sts.hit && !sts.is_clear;
				cmd.issue    = !sts.is_clear && !sts.hit && !sts.at_end;
			end
			S_UPDATE: begin
				cmd.update = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== hdl/kat_dpath.sv =====
// key and amount stores, search pointer and result register
`timescale 1ns / 1ps

module kat_dpath #(
	parameter int unsigned ENTRIES   = kat_pkg::ENTRIES_DEF,
	parameter int unsigned KEY_CHARS = kat_pkg::KEY_CHARS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  kat_pkg::cmd_t                     cmd,
	output kat_pkg::sts_t                     sts,
	input  logic [kat_pkg::KIND_W-1:0]        in_kind,
	input  logic [kat_pkg::KEY_W-1:0]         in_key,
	input  logic signed [kat_pkg::AMOUNT_W-1:0] in_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [kat_pkg::AMOUNT_W-1:0] out_amount,
	output logic [kat_pkg::SLOT_W-1:0]        out_slot,
	output logic [kat_pkg::STATUS_W-1:0]      out_status
);
	import kat_pkg::*;

	localparam int unsigned IDX_W = $clog2(ENTRIES);
	localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

	// stores
	logic [KEY_W-1:0]           key_mem [ENTRIES];
	logic signed [AMOUNT_W-1:0] amt_mem [ENTRIES];

	// request registers
	kind_t                      kind_q;
	logic [KEY_W-1:0]           key_q;
	logic signed [AMOUNT_W-1:0] value_q;

	// search state
	logic [CNT_W-1:0]           filled_q;
	logic [CNT_W-1:0]           idx_q;
	logic                       cmp_valid_s1;
	logic [IDX_W-1:0]           cmp_idx_s1;
	logic [KEY_W-1:0]           rd_key_s1;
	logic signed [AMOUNT_W-1:0] rd_amt_s1;
	logic                       found_q;
	logic [IDX_W-1:0]           slot_q;
	logic signed [AMOUNT_W-1:0] amt_q;

	// result register
	logic                       out_valid_q;
	logic signed [AMOUNT_W-1:0] out_amount_q;
	logic [SLOT_W-1:0]          out_slot_q;
	status_t                    out_status_q;

	// update decode
	logic                       is_full;
	logic                       do_insert;
	logic                       do_amt_wr;
	logic [IDX_W-1:0]           wr_idx;
	logic signed [AMOUNT_W-1:0] old_amt;
	logic signed [AMOUNT_W-1:0] new_amt;

	assign is_full   = (filled_q == CNT_W'(ENTRIES));
	assign do_insert = cmd.update && kind_q != KIND_CLEAR && !found_q && !is_full;
	assign do_amt_wr = cmd.update && kind_q != KIND_CLEAR && (found_q || !is_full);
	assign wr_idx    = found_q ? slot_q : filled_q[IDX_W-1:0];
	assign old_amt   = found_q ? amt_q : '0;

	// new amount after the operation, add wraps
	always_comb begin
		unique case (kind_q)
			KIND_WRITE: new_amt = value_q;
			KIND_ADD:   new_amt = old_amt + value_q;
			default:    new_amt = old_amt;
		endcase
	end

	// status towards the controller
	always_comb begin
		sts.is_clear  = (kind_q == KIND_CLEAR);
		sts.hit       = cmp_valid_s1 && (rd_key_s1 == key_q);
		sts.at_end    = (idx_q == filled_q);
		sts.exhausted = !cmp_valid_s1 && (idx_q == filled_q);
		sts.out_free  = !out_valid_q || out_ready;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q     <= '0;
			idx_q        <= '0;
			cmp_valid_s1 <= 1'b0;
			found_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			cmp_valid_s1 <= cmd.issue;
			if (cmd.accept) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else if (cmd.issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (cmd.take_hit) begin
				found_q <= 1'b1;
			end
			if (cmd.update && kind_q == KIND_CLEAR) begin
				filled_q <= '0;
			end else if (do_insert) begin
				filled_q <= filled_q + CNT_W'(1);
			end
			if (cmd.update) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request capture and hit capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q  <= kind_t'(in_kind);
			key_q   <= key_normalize(in_key, KEY_CHARS);
			value_q <= in_value;
		end
		if (cmd.take_hit) begin
			slot_q <= cmp_idx_s1;
			amt_q  <= rd_amt_s1;
		end
		if (cmd.issue) begin
			cmp_idx_s1 <= idx_q[IDX_W-1:0];
		end
	end

	// store reads, one entry per cycle during the scan
	always_ff @(posedge clk) begin
		rd_key_s1 <= key_mem[idx_q[IDX_W-1:0]];
		rd_amt_s1 <= amt_mem[idx_q[IDX_W-1:0]];
	end

	// store writes at the update step
	always_ff @(posedge clk) begin
		if (do_insert) begin
			key_mem[wr_idx] <= key_q;
		end
		if (do_amt_wr) begin
			amt_mem[wr_idx] <= new_amt;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			priority if (kind_q == KIND_CLEAR) begin
				out_amount_q <= '0;
				out_slot_q   <= '0;
				out_status_q <= STAT_CLEARED;
			end else if (found_q) begin
				out_amount_q <= new_amt;
				out_slot_q   <= SLOT_W'(slot_q);
				out_status_q <= STAT_HIT;
			end else if (is_full) begin
				out_amount_q <= '0;
				out_slot_q   <= '0;
				out_status_q <= STAT_FULL;
			end else begin
				out_amount_q <= new_amt;
				out_slot_q   <= SLOT_W'(filled_q[IDX_W-1:0]);
				out_status_q <= STAT_INSERTED;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_amount = out_amount_q;
	assign out_slot   = out_slot_q;
	assign out_status = out_status_q;

endmodule

// ===== hdl/keyed_accumulator_table_top.sv =====
// top level of the keyed accumulator table
`timescale 1ns / 1ps

// Table of signed 32-bit accumulators named by keys of up to four characters
// (first character in the lowest byte, ending at the first zero byte). Each
// request reads, overwrites or adds to a key's amount, inserting the key with
// amount zero on a miss, or clears the whole table. Requests are handled one
// at a time: the transfer is taken in the idle state, then, for all but a
// clear, the filled entries are scanned at one entry per cycle through the
// key store's single read port, stopping early on a hit, and the update step
// waits until the result register is free. The result waits in an output
// register, so the next request is taken while it is still held. A miss on a
// full table returns status full and changes nothing.
module keyed_accumulator_table_top #(
	parameter int unsigned ENTRIES   = kat_pkg::ENTRIES_DEF,
	parameter int unsigned KEY_CHARS = kat_pkg::KEY_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // key [31:0], value [63:32]
	input  logic [1:0]  s_axis_tuser,  // kind [1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // amount [31:0], slot [39:32]
	output logic [1:0]  m_axis_tuser   // status [1:0]
);
	import kat_pkg::*;

	cmd_t cmd;
	sts_t sts;

	logic signed [AMOUNT_W-1:0] out_amount;
	logic [SLOT_W-1:0]          out_slot;
	logic [STATUS_W-1:0]        out_status;

	// controller
	kat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	kat_dpath #(
		.ENTRIES   (ENTRIES),
		.KEY_CHARS (KEY_CHARS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_kind    (s_axis_tuser),
		.in_key     (s_axis_tdata[31:0]),
		.in_value   (s_axis_tdata[63:32]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_amount (out_amount),
		.out_slot   (out_slot),
		.out_status (out_status)
	);

	// result packing
	assign m_axis_tdata = {out_slot, out_amount};
	assign m_axis_tuser = out_status;

	// update only when the result register can take it
	a_update_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> sts.out_free)
		else $error("update while result register occupied");

	// a new request is never taken mid-scan or mid-update
	a_accept_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |-> (!cmd.update && !cmd.issue))
		else $error("request taken while busy");

	// every update shows a result on the next cycle
	a_update_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> m_axis_tvalid)
		else $error("update without result");

	// the scan stops issuing reads once a hit is seen
	a_hit_stops: assert property (@(posedge clk) disable iff (!arst_n)
		sts.hit |-> !cmd.issue)
		else $error("scan continued past a hit");

endmodule
